// File: src/lmbrs_pkg.sv
// Shared package for the LED matrix row scanner: geometry constants, command
// and operation codes, channel payload structs and the brightness lookup.
// No dependencies; every other file in src imports it.
package lmbrs_pkg;

   // Matrix geometry.
   localparam int ROWS = 8;
   localparam int COLS = 8;
   localparam int ROW_IDX_W = $clog2(ROWS);
   localparam int COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;

   // Field widths fixed by the interface.
   localparam int PIX_ROW_W   = 3;
   localparam int PIX_COL_W   = 3;
   localparam int COLOR_W     = 6;
   localparam int LEVEL_W     = 2;
   localparam int PASS_W      = 3;
   localparam int COLUMN_W    = 24;
   localparam int CHANNELS    = 3;
   localparam int LIT_W       = CHANNELS * COLS;

   // Modulation pass runs 1 to PASS_MAX and then wraps back to 1.
   localparam logic [PASS_W-1:0] PASS_FIRST = 3'd1;
   localparam logic [PASS_W-1:0] PASS_MAX   = 3'd7;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Command codes on the request channel.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_DRAW  = 2'd2;

   // Classified operations passed from front to back.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLAG  = 2'd2
   } op_type;

   typedef logic [COLOR_W-1:0] color_type;
   typedef color_type [COLS-1:0] row_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [PIX_ROW_W-1:0] pixel_row;
      logic [PIX_COL_W-1:0] pixel_col;
      logic [COLOR_W-1:0]   pixel_color;
      logic                 drawing_on;
   } req_type;

   typedef struct packed {
      logic [2:0]          row_index;
      logic                row_power;
      logic [COLUMN_W-1:0] column_bits;
      logic [PASS_W-1:0]   pass_index;
   } rsp_type;

   // One queued operation, with pixel coordinates already narrowed.
   typedef struct packed {
      op_type               op;
      logic [ROW_IDX_W-1:0] row;
      logic [COL_IDX_W-1:0] col;
      color_type            color;
      logic                 flag;
   } item_type;

   // A channel of the given level is lit on passes up to 1, 4 or every pass.
   function automatic logic channel_lit(input logic [LEVEL_W-1:0] level,
                                        input logic [PASS_W-1:0] pass);
      logic lit;
      case (level)
         2'd0:    lit = 1'b0;
         2'd1:    lit = (pass <= 3'd1);
         2'd2:    lit = (pass <= 3'd4);
         default: lit = 1'b1;
      endcase
      return lit;
   endfunction

endpackage

// File: src/lmbrs_front.sv
// Front part of the row scanner: accepts request transactions, classifies the
// command and drops pixel writes outside the matrix and unused commands.
// Depends on lmbrs_pkg.
module lmbrs_front (
   input  lmbrs_pkg::req_type  req_data,
   input  logic                req_valid,
   output logic                req_ready,
   output lmbrs_pkg::item_type push_data,
   output logic                push_valid,
   input  logic                push_ready
);
   import lmbrs_pkg::*;

   logic in_matrix;
   logic keep;

   // A pixel write counts only when it lands inside the matrix.
   assign in_matrix = (32'(req_data.pixel_row) < ROWS) && (32'(req_data.pixel_col) < COLS);

   // Classify the command into a queued operation.
   always_comb begin
      push_data.op    = OP_TICK;
      push_data.row   = ROW_IDX_W'(req_data.pixel_row);
      push_data.col   = COL_IDX_W'(req_data.pixel_col);
      push_data.color = req_data.pixel_color;
      push_data.flag  = req_data.drawing_on;
      keep            = 1'b0;
      case (req_data.command)
         CMD_TICK: begin
            push_data.op = OP_TICK;
            keep         = 1'b1;
         end
         CMD_PIXEL: begin
            push_data.op = OP_WRITE;
            keep         = in_matrix;
         end
         CMD_DRAW: begin
            push_data.op = OP_FLAG;
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Dropped transactions are still accepted, but only when the queue could
   // have taken them, so acceptance never depends on the payload.
   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule

// File: src/lmbrs_queue.sv
// Short FIFO that decouples the classifying front from the scanning back.
// Depends on lmbrs_pkg for the item type and depth.
module lmbrs_queue (
   input  logic                clock,
   input  logic                reset,
   input  lmbrs_pkg::item_type push_data,
   input  logic                push_valid,
   output logic                push_ready,
   output lmbrs_pkg::item_type pop_data,
   output logic                pop_valid,
   input  logic                pop_ready
);
   import lmbrs_pkg::*;

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (32'(count_ff) < QUEUE_DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 :
                     QUEUE_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 :
                     QUEUE_PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; occupancy guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/lmbrs_back.sv
// Back part of the row scanner: frame stores, scan row and pass counters,
// frame swap and the registered response stage.
// Depends on lmbrs_pkg.
module lmbrs_back (
   input  logic                clock,
   input  logic                reset,
   input  lmbrs_pkg::item_type pop_data,
   input  logic                pop_valid,
   output logic                pop_ready,
   output lmbrs_pkg::rsp_type  rsp_data,
   output logic                rsp_valid,
   input  logic                rsp_ready
);
   import lmbrs_pkg::*;

   row_type              front_ff [ROWS];
   row_type              back_ff  [ROWS];
   logic                 dirty_ff;
   logic                 drawing_ff;
   logic [ROW_IDX_W-1:0] scan_row_ff, scan_row_in;
   logic [PASS_W-1:0]    scan_pass_ff, scan_pass_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_data_ff, out_data_in;

   logic                 is_tick;
   logic                 do_pop;
   logic                 do_tick;
   logic                 do_write;
   logic                 do_flag;
   logic                 row_wrap;
   logic                 swap;
   row_type              row_data;
   logic [LIT_W-1:0]     lit;
   logic [COLUMN_W-1:0]  column_bits;

   // Ticks need a free response stage; other operations always drain.
   assign is_tick   = (pop_data.op == OP_TICK);
   assign pop_ready = !is_tick || !out_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign do_tick   = do_pop && is_tick;
   assign do_write  = do_pop && (pop_data.op == OP_WRITE);
   assign do_flag   = do_pop && (pop_data.op == OP_FLAG);

   // Next scan position.
   always_comb begin
      row_wrap     = (scan_row_ff == ROW_IDX_W'(ROWS - 1));
      scan_row_in  = row_wrap ? '0 : ROW_IDX_W'(scan_row_ff + 1'b1);
      scan_pass_in = scan_pass_ff;
      if (row_wrap) begin
         scan_pass_in = (scan_pass_ff == PASS_MAX) ? PASS_FIRST :
                        PASS_W'(scan_pass_ff + 1'b1);
      end
   end

   // Swap at the top of the first pass if the back frame was written, unless drawing holds it back.
   assign swap     = do_tick && (scan_row_in == '0) && (scan_pass_in == PASS_FIRST) &&
                     !drawing_ff && dirty_ff;
   assign row_data = swap ? back_ff[scan_row_in] : front_ff[scan_row_in];

   // Per-channel lit decision for every column of the row, in parallel.
   for (genvar c = 0; c < COLS; c++) begin : g_col
      for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
         assign lit[CHANNELS * c + k] =
            channel_lit(row_data[c][COLOR_W - LEVEL_W * (k + 1) +: LEVEL_W], scan_pass_in);
      end
   end

   // Keep the low bits of the column word, zero above the last column.
   for (genvar p = 0; p < COLUMN_W; p++) begin : g_bit
      if (p < LIT_W) begin : g_used
         assign column_bits[p] = lit[p];
      end else begin : g_unused
         assign column_bits[p] = 1'b0;
      end
   end

   // Response stage contents.
   always_comb begin
      out_data_in.row_index   = 3'(scan_row_in);
      out_data_in.row_power   = |lit;
      out_data_in.column_bits = column_bits;
      out_data_in.pass_index  = scan_pass_in;
      out_valid_in            = out_valid_ff;
      if (do_tick) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state and frame stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            front_ff[r] <= '0;
            back_ff[r]  <= '0;
         end
         dirty_ff     <= 1'b0;
         drawing_ff   <= 1'b0;
         scan_row_ff  <= ROW_IDX_W'(ROWS - 1);
         scan_pass_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (do_tick) begin
            scan_row_ff  <= scan_row_in;
            scan_pass_ff <= scan_pass_in;
         end
         if (swap) begin
            for (int r = 0; r < ROWS; r++) begin
               front_ff[r] <= back_ff[r];
            end
            dirty_ff <= 1'b0;
         end
         if (do_write) begin
            back_ff[pop_data.row][pop_data.col] <= pop_data.color;
            dirty_ff                            <= 1'b1;
         end
         if (do_flag) begin
            drawing_ff <= pop_data.flag;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (do_tick) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: src/led_matrix_bcm_row_scanner_core.sv
// Top level of the LED matrix row scanner: joins front, queue and back parts.
// Depends on lmbrs_pkg, lmbrs_front, lmbrs_queue and lmbrs_back.
//
// Usage:
//   The request channel (req_valid, req_ready, req_data) carries commands:
//   a scan tick, a pixel write into the back frame, or a drawing flag update.
//   Pixel writes outside the matrix and unused command codes are accepted
//   and discarded. Only a scan tick produces a response on the rsp channel
//   (rsp_valid, rsp_ready, rsp_data): the row driven, its column drive bits,
//   a row power bit and the modulation pass.
//   A tick's response passes through the two-entry queue and then the
//   response register before it is shown on the rsp channel.
//   Throughput: one transaction per cycle while rsp_ready stays high; the
//   whole row is evaluated in parallel from a flip-flop frame store, and a
//   frame swap loads every row of the front frame in the same cycle.
//   When the receiver stalls, the response register holds its transaction;
//   pixel writes and flag updates behind it keep draining, and the queue
//   fills with up to two entries before req_ready falls.
//   Reset clears both frames to dark, the dirty and drawing flags, and sets
//   the scan so that the first tick drives row 0 of pass 1.
module led_matrix_bcm_row_scanner_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lmbrs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lmbrs_pkg::rsp_type rsp_data
);
   import lmbrs_pkg::*;

   item_type push_data;
   logic     push_valid;
   logic     push_ready;
   item_type pop_data;
   logic     pop_valid;
   logic     pop_ready;

   // Classify incoming transactions.
   lmbrs_front u_front (
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // Decoupling queue.
   lmbrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // Frame stores, scan and response.
   lmbrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

// File: verif/led_matrix_bcm_row_scanner_tb.sv
// Testbench for led_matrix_bcm_row_scanner_core: directed table, then random command streams.
// Every response is checked against a scan predictor held in this file.
// Depends on lmbrs_pkg and the core RTL under src.
module testbench;
   import lmbrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Command code that the block accepts and discards.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Last pass on which each brightness level is lit.
   localparam int LEVEL1_LAST = 1;
   localparam int LEVEL2_LAST = 4;
   localparam int LEVEL3_LAST = 8;

   localparam int RANDOM_ITEMS  = 2000;
   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_LINES  = 30;

   // One row of the directed table; a typed row carries its own expected scan.
   typedef struct packed {
      req_type    req;
      logic [7:0] count;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Typed expectation travelling alongside the request it belongs to.
   logic    pinned_check = 1'b0;
   rsp_type pinned_scan = '0;

   // Predictor state.
   row_type           front_frame [ROWS];
   row_type           back_frame [ROWS];
   logic              back_dirty;
   logic              drawing;
   int                scan_row;
   logic [PASS_W-1:0] scan_pass;

   rsp_type      expected_scans [$];
   stim_row_type directed_steps [$];

   int mismatch_count = 0;
   int stall_cycles = 0;
   int scans_checked = 0;
   int tick_count = 0;
   int write_count = 0;
   int flag_count = 0;
   int ignored_count = 0;
   int swap_count = 0;

   led_matrix_bcm_row_scanner_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Prints one line per mismatch, up to a limit, and counts every one.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
      end
   endtask

   // Applies one command to the predictor and yields the scan it drives, if any.
   task automatic scan_predict(input req_type r, output logic produced, output rsp_type res);
      color_type         px;
      logic [LEVEL_W-1:0] level;
      int                last_pass;
      int                pos;
      produced = 1'b0;
      res = '0;
      case (r.command)
         CMD_PIXEL: begin
            write_count++;
            if (r.pixel_row < ROWS && r.pixel_col < COLS) begin
               back_frame[r.pixel_row][r.pixel_col] = r.pixel_color;
               back_dirty = 1'b1;
            end
         end
         CMD_DRAW: begin
            flag_count++;
            drawing = r.drawing_on;
         end
         CMD_TICK: begin
            tick_count++;
            // Step the row; a wrap moves to the next pass, 7 wrapping back to 1.
            if (scan_row == ROWS - 1) begin
               scan_row = 0;
               scan_pass = (scan_pass == PASS_MAX) ? PASS_FIRST : scan_pass + 1'b1;
            end else begin
               scan_row++;
            end
            // The back frame is shown only at the top of the first pass.
            if (scan_row == 0 && scan_pass == PASS_FIRST && !drawing && back_dirty) begin
               front_frame = back_frame;
               back_dirty = 1'b0;
               swap_count++;
            end
            for (int c = 0; c < COLS; c++) begin
               px = front_frame[scan_row][c];
               for (int k = 0; k < CHANNELS; k++) begin
                  level = px[4 - 2 * k +: 2];
                  last_pass = (level == 2'd1) ? LEVEL1_LAST :
                              (level == 2'd2) ? LEVEL2_LAST : LEVEL3_LAST;
                  if (level != 2'd0 && scan_pass <= last_pass) begin
                     pos = CHANNELS * c + k;
                     if (pos < COLUMN_W) res.column_bits[pos] = 1'b1;
                     res.row_power = 1'b1;
                  end
               end
            end
            res.row_index = scan_row[2:0];
            res.pass_index = scan_pass;
            produced = 1'b1;
         end
         default: ignored_count++;
      endcase
   endtask

   task automatic table_add(input logic [1:0] cmd, input logic [2:0] prow, input logic [2:0] pcol,
                            input logic [5:0] color, input logic flag, input logic [7:0] count,
                            input logic typed, input rsp_type want);
      stim_row_type s;
      s.req = {cmd, prow, pcol, color, flag};
      s.count = count;
      s.typed = typed;
      s.want = want;
      directed_steps.push_back(s);
   endtask

   function automatic req_type random_request(input logic [1:0] cmd);
      req_type r;
      r.command = cmd;
      r.pixel_row = 3'($urandom_range(0, 7));
      r.pixel_col = 3'($urandom_range(0, 7));
      r.pixel_color = 6'($urandom_range(0, 63));
      r.drawing_on = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Offers one transaction, after a random gap when idling is allowed,
   // and returns on the edge at which it is accepted.
   task automatic push_request(input req_type r, input logic idle_ok, input logic typed,
                               input rsp_type want);
      int p;
      int gap;
      gap = 0;
      if (idle_ok) begin
         p = $urandom_range(0, 99);
         if (p < 50) gap = 0;
         else if (p < 85) gap = $urandom_range(1, 3);
         else if (p < 97) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      pinned_check <= typed;
      pinned_scan <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the request channel idle until every predicted scan has arrived.
   task automatic drain_scans();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_scans.size() != 0) @(posedge clock);
   endtask

   // Receiver: full-speed stretches, short random stalls and a few long ones.
   initial begin : receiver
      int p;
      int run;
      forever begin
         p = $urandom_range(0, 99);
         if (p < 35) begin
            rsp_ready <= 1'b1;
            run = $urandom_range(1, 50);
         end else if (p < 90) begin
            rsp_ready <= 1'($urandom_range(0, 1));
            run = $urandom_range(1, 3);
         end else if (p < 97) begin
            rsp_ready <= 1'b0;
            run = $urandom_range(4, 12);
         end else begin
            rsp_ready <= 1'b0;
            run = $urandom_range(20, 60);
         end
         repeat (run) @(posedge clock);
      end
   end

   // Predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin : scoreboard
      logic    produced;
      rsp_type predicted;
      rsp_type oldest;
      if (!reset) begin
         if (req_valid && req_ready) begin
            scan_predict(req_data, produced, predicted);
            if (produced) expected_scans.push_back(pinned_check ? pinned_scan : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            scans_checked++;
            if (expected_scans.size() == 0) begin
               report_mismatch("unexpected scan, row", 32'(rsp_data.row_index), 0);
            end else begin
               oldest = expected_scans.pop_front();
               if (rsp_data.row_index !== oldest.row_index)
                  report_mismatch("row_index", 32'(rsp_data.row_index),
                                  32'(oldest.row_index));
               if (rsp_data.row_power !== oldest.row_power)
                  report_mismatch("row_power", 32'(rsp_data.row_power),
                                  32'(oldest.row_power));
               if (rsp_data.column_bits !== oldest.column_bits)
                  report_mismatch("column_bits", 32'(rsp_data.column_bits),
                                  32'(oldest.column_bits));
               if (rsp_data.pass_index !== oldest.pass_index)
                  report_mismatch("pass_index", 32'(rsp_data.pass_index),
                                  32'(oldest.pass_index));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   // Ends the run when no transaction has moved for too long.
   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      req_type r;
      int      sent;
      int      n;
      int      p;
      logic    calm;
      logic    paused;

      // Predictor starts from the reset state: dark frames, first tick on row 0 of pass 1.
      foreach (front_frame[i]) begin
         front_frame[i] = '0;
         back_frame[i] = '0;
      end
      back_dirty = 1'b0;
      drawing = 1'b0;
      scan_row = ROWS - 1;
      scan_pass = '0;

      // Directed table. An unused command with every field high, pixel writes at
      // three corners and one inside, then a first tick that swaps the frame in at once.
      table_add(CMD_UNUSED, 3'd7, 3'd7, 6'd63, 1'b1, 8'd1, 1'b0, '0);
      table_add(CMD_PIXEL, 3'd0, 3'd0, 6'b111111, 1'b0, 8'd1, 1'b0, '0);
      table_add(CMD_PIXEL, 3'd0, 3'd7, 6'b101010, 1'b0, 8'd1, 1'b0, '0);
      table_add(CMD_PIXEL, 3'd7, 3'd7, 6'b010101, 1'b0, 8'd1, 1'b0, '0);
      table_add(CMD_PIXEL, 3'd3, 3'd4, 6'b110100, 1'b0, 8'd1, 1'b0, '0);
      table_add(CMD_DRAW, 3'd7, 3'd7, 6'd63, 1'b0, 8'd1, 1'b0, '0);
      table_add(CMD_TICK, 3'd0, 3'd0, 6'd0, 1'b0, 8'd1, 1'b1,
                {3'd0, 1'b1, 24'hE00007, PASS_FIRST});
      // Drawing flag raised: new writes stay in the back frame.
      table_add(CMD_DRAW, 3'd0, 3'd0, 6'd0, 1'b1, 8'd1, 1'b0, '0);
      table_add(CMD_PIXEL, 3'd1, 3'd1, 6'b111111, 1'b1, 8'd1, 1'b0, '0);
      table_add(CMD_PIXEL, 3'd0, 3'd0, 6'd0, 1'b0, 8'd1, 1'b0, '0);
      table_add(CMD_TICK, 3'd0, 3'd0, 6'd0, 1'b0, 8'd6, 1'b0, '0);
      table_add(CMD_TICK, 3'd7, 3'd7, 6'd63, 1'b1, 8'd1, 1'b1,
                {3'd7, 1'b1, 24'hE00000, PASS_FIRST});
      // Wrap into pass 2: row 0's level-two and -three pixels stay lit, no swap off the first pass.
      table_add(CMD_TICK, 3'd0, 3'd0, 6'd0, 1'b0, 8'd1, 1'b1,
                {3'd0, 1'b1, 24'hE00007, 3'd2});
      table_add(CMD_DRAW, 3'd5, 3'd2, 6'd21, 1'b0, 8'd1, 1'b0, '0);
      table_add(CMD_TICK, 3'd0, 3'd0, 6'd0, 1'b0, 8'd4, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         repeat (directed_steps[i].count) begin
            push_request(directed_steps[i].req, 1'b1, directed_steps[i].typed,
                         directed_steps[i].want);
         end
      end
      drain_scans();

      // Random part: mostly well-formed frame updates and tick runs, some noise.
      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         p = $urandom_range(0, 99);
         if (p < 30) begin
            // Redraw under the drawing flag, then release it.
            r = random_request(CMD_DRAW);
            r.drawing_on = 1'b1;
            push_request(r, !calm, 1'b0, '0);
            n = $urandom_range(1, 12);
            repeat (n) push_request(random_request(CMD_PIXEL), !calm, 1'b0, '0);
            r = random_request(CMD_DRAW);
            r.drawing_on = 1'b0;
            push_request(r, !calm, 1'b0, '0);
            sent += n + 2;
         end else if (p < 70) begin
            n = $urandom_range(1, 70);
            repeat (n) push_request(random_request(CMD_TICK), !calm, 1'b0, '0);
            sent += n;
         end else if (p < 85) begin
            n = $urandom_range(1, 10);
            repeat (n) begin
               r = random_request(2'($urandom_range(0, 3)));
               push_request(r, !calm, 1'b0, '0);
               if (r.command != CMD_UNUSED) sent++;
            end
         end else begin
            // Writes straight into a frame that may be swapped at any moment.
            n = $urandom_range(1, 6);
            repeat (n) push_request(random_request(CMD_PIXEL), !calm, 1'b0, '0);
            sent += n;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            drain_scans();
            paused = 1'b1;
         end
      end

      drain_scans();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d scan ticks, %0d pixel writes, %0d flag updates, %0d unused commands.",
               tick_count, write_count, flag_count, ignored_count);
      $display("Frame swaps predicted: %0d; scans checked: %0d; mismatches: %0d.",
               swap_count, scans_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
